### rtl/core/mexp_pkg.sv
// mexp_pkg: shared types and constants of the modular exponentiation unit
// used by mexp_mulmod and modular_exponentiation_unit; no dependencies
`default_nettype none

package mexp_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } mexp_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

endpackage

`default_nettype wire

### rtl/core/modular_exponentiation_unit.sv
// modular_exponentiation_unit: base ^ exponent mod modulus, right-to-left
// square-and-multiply sequenced over one shared modular multiplier
// depends on mexp_pkg and mexp_mulmod
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  s_tdata: base_value
//  m_        out        m_tvalid / m_tready  m_tdata: power_result
//  cfg_      in         cfg_wr_en            cfg_wr_index, cfg_wr_data
//
// an item runs one base reduction, WIDTH squarings and one multiply per set
// exponent bit, all on the shared multiplier
// a zero modulus gives 0 without using the multiplier
// s_tready is low while an item is at work; the output register lets the next
// item start while a result waits; aresetn is synchronous, active low
`default_nettype none

module modular_exponentiation_unit
    import mexp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [DATA_W-1:0]    s_tdata,      // [31:0] base_value
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [DATA_W-1:0]    m_tdata,      // [31:0] power_result
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [DATA_W-1:0]    cfg_wr_data
);

    localparam int BIT_W = $clog2(WIDTH);

    mexp_state_t state_reg, state_next;

    logic [DATA_W-1:0] modulus_reg;
    logic [DATA_W-1:0] exponent_reg;

    logic [WIDTH-1:0]  acc_reg, acc_next;
    logic [WIDTH-1:0]  pow_reg, pow_next;
    logic [WIDTH-1:0]  exp_reg, exp_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic              out_valid_reg, out_valid_next;
    logic [WIDTH-1:0]  out_data_reg, out_data_next;

    logic [WIDTH-1:0]  mod_w;
    logic              mod_zero;
    logic              in_xfer;
    logic              last_bit;
    logic              out_free;

    logic              mm_start;
    logic [WIDTH-1:0]  mm_x;
    logic [WIDTH-1:0]  mm_y;
    logic [WIDTH-1:0]  mm_result;
    mm_stat_t          mm_stat;
    logic              load_out;

    assign mod_w    = modulus_reg[WIDTH-1:0];
    assign mod_zero = (mod_w == '0);
    assign in_xfer  = s_tvalid && s_tready;
    assign last_bit = (bit_reg == BIT_W'(WIDTH - 1));
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= DATA_W'(1);
            exponent_reg <= DATA_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_MODULUS:  modulus_reg  <= cfg_wr_data;
                CFG_EXPONENT: exponent_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    mexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .op_x    (mm_x),
        .op_y    (mm_y),
        .modulus (mod_w),
        .result  (mm_result),
        .stat    (mm_stat)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = mod_zero ? ST_DONE : ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (mm_stat.done) begin
                    state_next = exp_reg[0] ? ST_MUL : ST_SQR;
                end
            end
            ST_MUL: begin
                if (mm_stat.done) begin
                    state_next = ST_SQR;
                end
            end
            ST_SQR: begin
                if (mm_stat.done) begin
                    if (last_bit) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = exp_reg[1] ? ST_MUL : ST_SQR;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready = 1'b0;
        mm_start = 1'b0;
        mm_x     = pow_reg;
        mm_y     = pow_reg;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_REDUCE: begin
                mm_start = !mm_stat.busy && !mm_stat.done;
                mm_y     = WIDTH'(1);
            end
            ST_MUL: begin
                mm_start = !mm_stat.busy && !mm_stat.done;
                mm_x     = acc_reg;
            end
            ST_SQR: begin
                mm_start = !mm_stat.busy && !mm_stat.done;
            end
            ST_DONE: begin
                load_out = out_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        acc_next       = acc_reg;
        pow_next       = pow_reg;
        exp_next       = exp_reg;
        bit_next       = bit_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (in_xfer) begin
            acc_next = mod_zero ? '0 : WIDTH'(1);
            pow_next = s_tdata[WIDTH-1:0];
            exp_next = exponent_reg[WIDTH-1:0];
            bit_next = '0;
        end
        if (mm_stat.done) begin
            case (state_reg)
                ST_REDUCE: pow_next = mm_result;
                ST_MUL:    acc_next = mm_result;
                ST_SQR: begin
                    pow_next = mm_result;
                    exp_next = exp_reg >> 1;
                    bit_next = bit_reg + BIT_W'(1);
                end
                default: ;
            endcase
        end
        if (load_out) begin
            out_valid_next = 1'b1;
            out_data_next  = acc_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bit_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_reg       <= bit_next;
        end
        acc_reg      <= acc_next;
        pow_reg      <= pow_next;
        exp_reg      <= exp_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'(out_data_reg);

    a_mm_result_reduced: assert property (
        @(posedge aclk) disable iff (!aresetn)
        mm_stat.done |-> (mm_result < mod_w)
    ) else $error("multiplier result not below modulus");

    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready
    ) else $error("input ready right after an accepted transfer");

    a_idle_mm_quiet: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mm_stat.busy
    ) else $error("multiplier busy while sequencer idle");

    a_load_only_free: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata)
    ) else $error("pending result overwritten or dropped");

endmodule

`default_nettype wire

### rtl/core/mexp_mulmod.sv
// mexp_mulmod: shared bit-serial modular multiplier, x * y mod m, msb first
// one multiplier bit per cycle with a shift-add and a double compare-subtract
// depends on mexp_pkg
`default_nettype none

module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] op_x,
    input  wire logic [WIDTH-1:0] op_y,
    input  wire logic [WIDTH-1:0] modulus,
    output logic      [WIDTH-1:0] result,
    output mm_stat_t              stat
);

    localparam int CNT_W = $clog2(WIDTH);
    localparam int T_W   = WIDTH + 2;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH-1:0] x_reg, x_next;
    logic [WIDTH-1:0] y_reg, y_next;
    logic [WIDTH-1:0] r_reg, r_next;

    logic [T_W-1:0] sum;
    logic [T_W-1:0] m1;
    logic [T_W-1:0] m2;
    logic [T_W-1:0] sum_red;

    // r < m and y <= m keep 2r + y below 3m
    always_comb begin
        sum = {1'b0, r_reg, 1'b0} + (x_reg[WIDTH-1] ? T_W'(y_reg) : T_W'(0));
        m1  = T_W'(modulus);
        m2  = {1'b0, modulus, 1'b0};
        if (sum >= m2) begin
            sum_red = sum - m2;
        end else if (sum >= m1) begin
            sum_red = sum - m1;
        end else begin
            sum_red = sum;
        end
    end

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        y_next    = y_reg;
        r_next    = r_reg;
        if (busy_reg) begin
            r_next   = sum_red[WIDTH-1:0];
            x_next   = {x_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            x_next    = op_x;
            y_next    = op_y;
            r_next    = '0;
            cnt_next  = CNT_W'(WIDTH - 1);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        r_reg <= r_next;
    end

    assign result    = r_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

### tb/tb.sv
// tb: self-checking bench for modular_exponentiation_unit, base ^ exponent mod modulus
// a scoreboard class predicts each power on its own; tasks drive the stream and config ports
// depends on mexp_pkg and modular_exponentiation_unit
module tb;
    import mexp_pkg::*;

    localparam int CYCLE_LIMIT = 8000000;
    localparam int ITEM_CYCLES = 2300;
    localparam int HOLD_CYCLES = 6000;

    typedef enum {RDY_ALWAYS, RDY_STALL, RDY_COIN} ready_mode_t;

    class power_scoreboard;
        logic [DATA_W-1:0] modulus;
        logic [DATA_W-1:0] exponent;
        logic [DATA_W-1:0] expected_powers[$];
        int errors;

        function new();
            modulus  = 1;
            exponent = 1;
            errors   = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                CFG_MODULUS:  modulus  = value;
                CFG_EXPONENT: exponent = value;
                default: ;
            endcase
        endfunction

        // right-to-left square-and-multiply, every product reduced at once
        function void note_base(logic [DATA_W-1:0] base);
            longint unsigned m;
            longint unsigned b;
            longint unsigned acc;
            m   = modulus;
            b   = base;
            acc = 1;
            if (m == 0) begin
                acc = 0;
            end else begin
                b = b % m;
                for (int i = 0; i < DATA_W; i++) begin
                    if (exponent[i]) acc = (acc * b) % m;
                    b = (b * b) % m;
                end
            end
            expected_powers.push_back(acc[DATA_W-1:0]);
        endfunction

        function void check_power(logic [DATA_W-1:0] actual);
            logic [DATA_W-1:0] want;
            if (expected_powers.size() == 0) begin
                $display("%0t: unexpected power_result, expected none, actual %h", $time, actual);
                errors++;
            end else begin
                want = expected_powers.pop_front();
                if (actual !== want) begin
                    $display("%0t: power_result mismatch, expected %h, actual %h",
                             $time, want, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DATA_W-1:0]    m_tdata;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_wr_index;
    logic [DATA_W-1:0]    cfg_wr_data;

    power_scoreboard sb;
    int              burst_left;
    int              cycle_count;
    bit              hold_off_req;

    modular_exponentiation_unit DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[modular_exponentiation_unit] ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) sb.check_power(m_tdata);
    end

    // one base transfer; bursts of random length separated by random gaps
    task automatic send_base(input logic [DATA_W-1:0] base);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 2500);
                default: gap = $urandom_range(1, 20);
            endcase
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= base;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        sb.note_base(base);
    endtask

    // let every pending power come out, then write both registers
    task automatic drain_and_set(input logic [DATA_W-1:0] mod_v, input logic [DATA_W-1:0] exp_v);
        s_tvalid <= 1'b0;
        while (sb.expected_powers.size() != 0) @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= CFG_MODULUS;
        cfg_wr_data  <= mod_v;
        @(posedge aclk);
        sb.set_register(CFG_MODULUS, mod_v);
        cfg_wr_index <= CFG_EXPONENT;
        cfg_wr_data  <= exp_v;
        @(posedge aclk);
        sb.set_register(CFG_EXPONENT, exp_v);
        cfg_wr_en <= 1'b0;
        burst_left = 0;
    endtask

    function automatic logic [DATA_W-1:0] pick_modulus();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 1;
            2: return '1;
            3: return $urandom_range(2, 255);
            4: return {1'b1, 31'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_exponent();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 1 << $urandom_range(0, DATA_W - 1);
            3: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_base(input logic [DATA_W-1:0] mod_v);
        case ($urandom_range(0, 11))
            0: return '0;
            1: return 1;
            2: return '1;
            3: return mod_v - 1;
            4: return mod_v;
            5: return mod_v + 1;
            default: return $urandom;
        endcase
    endfunction

    initial begin : receiver
        int          seg_len;
        ready_mode_t seg_mode;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            seg_len = $urandom_range(1, 64);
            case ($urandom_range(0, 3))
                0: seg_mode = RDY_STALL;
                1: seg_mode = RDY_COIN;
                default: seg_mode = RDY_ALWAYS;
            endcase
            repeat (seg_len) begin
                case (seg_mode)
                    RDY_STALL: m_tready <= 1'b0;
                    RDY_COIN:  m_tready <= 1'($urandom_range(0, 1));
                    default:   m_tready <= 1'b1;
                endcase
                @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        logic [DATA_W-1:0] mod_v;
        logic [DATA_W-1:0] exp_v;
        sb           = new();
        burst_left   = 0;
        cycle_count  = 0;
        hold_off_req = 1'b0;
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_index <= CFG_MODULUS;
        cfg_wr_data  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register values from reset
        send_base('0);
        send_base('1);

        // zero modulus gives zero for any exponent
        drain_and_set('0, '1);
        send_base(32'd5);
        send_base('1);
        drain_and_set('0, '0);
        send_base(32'd9);

        // zero exponent gives one, even with modulus one
        drain_and_set(32'd1, '0);
        send_base('0);
        send_base('1);
        drain_and_set('1, '0);
        send_base(32'd7);

        drain_and_set('1, '1);
        send_base('0);
        send_base(32'd1);
        send_base(32'd2);
        send_base(32'h8000_0000);
        send_base(32'hFFFF_FFFE);
        send_base('1);

        // largest 32-bit prime, fermat exponent
        drain_and_set(32'hFFFF_FFFB, 32'hFFFF_FFFA);
        send_base(32'd2);
        send_base(32'hFFFF_FFFB);
        send_base(32'hFFFF_FFFC);

        drain_and_set(32'd2, 32'h8000_0000);
        send_base(32'd3);
        send_base(32'd4);

        drain_and_set(32'd3233, 32'd17);
        send_base(32'd65);
        send_base('0);

        for (int phase = 0; phase < 9; phase++) begin
            mod_v = pick_modulus();
            exp_v = pick_exponent();
            if (phase == 3) begin
                mod_v = {1'b1, 31'($urandom)};
                exp_v = $urandom;
            end
            drain_and_set(mod_v, exp_v);
            for (int k = 0; k < 30; k++) begin
                // receiver blocks for a long stretch while bases keep coming
                if (phase == 3 && k == 8) begin
                    hold_off_req = 1'b1;
                    burst_left   = 12;
                end
                send_base(pick_base(mod_v));
            end
        end

        s_tvalid <= 1'b0;
        while (sb.expected_powers.size() != 0) @(posedge aclk);
        repeat (ITEM_CYCLES) @(posedge aclk);
        if (sb.expected_powers.size() != 0)
            $display("%0t: %0d power results never arrived", $time, sb.expected_powers.size());
        if (sb.errors == 0 && sb.expected_powers.size() == 0) begin
            $display("[modular_exponentiation_unit] OK");
        end else begin
            $display("[modular_exponentiation_unit] ERROR");
        end
        $finish;
    end
endmodule
